### sv/hbbc_pkg.sv
// ----------------------------------------------------------------------------
// hbbc_pkg
// Shared types and constants for the hashed block buffer cache.
// ----------------------------------------------------------------------------
package hbbc_pkg;

   localparam int BUFFERS_DEF = 32;
   localparam int BUCKETS_DEF = 13;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef enum logic [1:0] {
      ACT_GET     = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_PIN     = 2'd2,
      ACT_UNPIN   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_MOD,
      S_CNT_RD,
      S_CNT_WR,
      S_HEAD_RD,
      S_HIT_WALK,
      S_FREE_WALK,
      S_UNLINK,
      S_PUSH,
      S_RETAG,
      S_HIT_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  device;
      logic [31:0] block_number;
      logic [4:0]  buffer_index;
   } req_type;

   typedef struct packed {
      logic [4:0] granted_buffer;
      logic       tag_hit;
      logic       needs_disk_read;
      logic [1:0] status;
   } rsp_type;

endpackage

### sv/hbbc_if.sv
// ----------------------------------------------------------------------------
// hbbc_if
// Valid/ready channel carrying one packed word.
// ----------------------------------------------------------------------------
interface hbbc_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### sv/hashed_block_buffer_cache_unit.sv
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_unit
// Buffer tag table with hashed bucket lists and buffer stealing.
// ----------------------------------------------------------------------------
// One request word in, one response word out. After reset the unit clears the
// tag and count memories and builds the bucket lists, and accepts nothing until
// done. Release, pin and unpin read the count and then write it back.
// A get first takes the modulo by BUCKETS (fold of the upper half, then a
// reciprocal multiply, then a subtract), then walks the bucket lists one node
// per cycle through the link memory, which has one read port: the hit walk over
// the home bucket, then the free walk, plus a walk over the other buckets when
// stealing.
module hashed_block_buffer_cache_unit
   import hbbc_pkg::*;
#(
   parameter int BUFFERS = BUFFERS_DEF,
   parameter int BUCKETS = BUCKETS_DEF
) (
   input logic  clock,
   input logic  reset,
   hbbc_if.sink   req,
   hbbc_if.source rsp
);
   localparam int NODES = BUFFERS + BUCKETS;
   localparam int NW    = $clog2(NODES + 1);
   localparam int BW    = $clog2(BUFFERS);
   localparam int KW    = $clog2(BUCKETS + 1);
   // 2^16 mod BUCKETS folds the upper half; reciprocal valid for 21-bit folds
   localparam int FOLD_K  = (1 << 16) % BUCKETS;
   localparam int MOD_MUL = ((1 << 26) + BUCKETS - 1) / BUCKETS;

   // memories: tags, counts, links
   logic [7:0]    tdev_mem [BUFFERS];
   logic [31:0]   tblk_mem [BUFFERS];
   logic [7:0]    cnt_mem  [BUFFERS];
   logic [NW-1:0] nxt_mem  [NODES];
   logic [NW-1:0] prv_mem  [NODES];
   logic [BUFFERS-1:0] valid_ff, valid_in;

   state_type state_ff, state_in;
   req_type   rq_ff, rq_in;
   rsp_type   rs_ff, rs_in;
   logic [NW-1:0] cur_ff, cur_in, head_ff, head_in, p_ff, p_in, q_ff, q_in;
   logic [KW-1:0] home_ff, home_in, bk_ff, bk_in;
   logic [20:0]   fold_ff, fold_in, quo_ff, quo_in;
   logic [5:0]    bit_ff, bit_in;
   logic [6:0]    steps_ff, steps_in;
   logic          steal_ff, steal_in;
   logic [1:0]    sub_ff, sub_in;

   // memory ports
   logic [NW-1:0] la, lwa;
   logic [NW-1:0] nxt_rd, prv_rd, lnwd, lpwd;
   logic          lnwe, lpwe;
   logic [BW-1:0] ta;
   logic [7:0]    tdev_rd, cnt_rd, cwd, tdwd;
   logic [31:0]   tblk_rd, tbwd;
   logic          twe, cwe;

   always_ff @(posedge clock) begin
      nxt_rd  <= nxt_mem[la];
      prv_rd  <= prv_mem[la];
      tdev_rd <= tdev_mem[ta];
      tblk_rd <= tblk_mem[ta];
      cnt_rd  <= cnt_mem[ta];
      if (lnwe) nxt_mem[lwa] <= lnwd;
      if (lpwe) prv_mem[lwa] <= lpwd;
      if (twe) begin
         tdev_mem[ta] <= tdwd;
         tblk_mem[ta] <= tbwd;
      end
      if (cwe) cnt_mem[ta] <= cwd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         valid_ff <= '0;
         cur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         cur_ff   <= cur_in;
      end
      rq_ff <= rq_in; rs_ff <= rs_in; head_ff <= head_in; p_ff <= p_in;
      q_ff <= q_in; home_ff <= home_in; bk_ff <= bk_in; fold_ff <= fold_in;
      quo_ff <= quo_in; bit_ff <= bit_in; steps_ff <= steps_in;
      steal_ff <= steal_in; sub_ff <= sub_in;
   end

   logic [NW-1:0] hnode;
   logic [47:0]   mprod;
   logic [20:0]   modv;
   logic          is_buf;

   always_comb begin
      state_in = state_ff; rq_in = rq_ff; rs_in = rs_ff; cur_in = cur_ff;
      head_in = head_ff; p_in = p_ff; q_in = q_ff; home_in = home_ff;
      bk_in = bk_ff; fold_in = fold_ff; quo_in = quo_ff; bit_in = bit_ff;
      steps_in = steps_ff; steal_in = steal_ff; sub_in = sub_ff; valid_in = valid_ff;
      la = cur_ff; lwa = cur_ff; lnwd = '0; lpwd = '0; lnwe = 1'b0; lpwe = 1'b0;
      ta = cur_ff[BW-1:0]; twe = 1'b0; cwe = 1'b0; cwd = cnt_rd;
      tdwd = rq_ff.device; tbwd = rq_ff.block_number;
      req.ready = 1'b0; rsp.valid = 1'b0; rsp.data = rs_ff;
      mprod = '0; modv = '0; hnode = '0;
      is_buf = cur_ff < NW'(BUFFERS);
      case (state_ff)
         // build: buffers 0..B-1 chained descending, heads self or list;
         // tags and counts cleared on the way
         S_INIT: begin
            lnwe = 1'b1; lpwe = 1'b1;
            twe = is_buf; cwe = is_buf; cwd = '0; tdwd = '0; tbwd = '0;
            if (cur_ff < NW'(BUFFERS)) begin
               lnwd = (cur_ff == '0) ? NW'(BUFFERS) : cur_ff - 1'b1;
               lpwd = (cur_ff == NW'(BUFFERS - 1)) ? NW'(BUFFERS) : cur_ff + 1'b1;
            end else if (cur_ff == NW'(BUFFERS)) begin
               lnwd = NW'(BUFFERS - 1);
               lpwd = '0;
            end else begin
               lnwd = cur_ff; lpwd = cur_ff;
            end
            if (cur_ff == NW'(NODES - 1)) state_in = S_IDLE;
            cur_in = cur_ff + 1'b1;
         end
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               rq_in = req.data;
               rs_in = '{granted_buffer: req.data.buffer_index, tag_hit: 1'b0,
                         needs_disk_read: 1'b0, status: ST_OK};
               if (req.data.action == ACT_GET) begin
                  bit_in = '0; state_in = S_MOD;
               end else if (32'(req.data.buffer_index) < 32'(BUFFERS)) begin
                  cur_in = NW'(req.data.buffer_index); state_in = S_CNT_RD;
               end else state_in = S_RESP;
            end
         end
         // remainder by BUCKETS: fold, reciprocal quotient, subtract
         S_MOD: begin
            if (bit_ff == 6'd0) begin
               fold_in = 21'(rq_ff.block_number[31:16]) * 21'(FOLD_K)
                       + 21'(rq_ff.block_number[15:0]);
               bit_in = 6'd1;
            end else if (bit_ff == 6'd1) begin
               mprod  = 48'(fold_ff) * 48'(MOD_MUL);
               quo_in = mprod[46:26];
               bit_in = 6'd2;
            end else begin
               modv = fold_ff - quo_ff * 21'(BUCKETS);
               home_in = KW'(modv);
               head_in = NW'(BUFFERS) + NW'(modv);
               cur_in  = NW'(BUFFERS) + NW'(modv);
               la = NW'(BUFFERS) + NW'(modv);
               steps_in = '0; sub_in = 2'd0; steal_in = 1'b0;
               state_in = S_HEAD_RD;
            end
         end
         S_CNT_RD: state_in = S_CNT_WR;
         S_CNT_WR: begin
            if (rq_ff.action == ACT_PIN) begin
               if (cnt_rd == COUNT_MAX) rs_in.status = ST_SATURATED;
               else begin cwe = 1'b1; cwd = cnt_rd + 1'b1; end
            end else begin
               if (cnt_rd == '0) rs_in.status = ST_UNDERFLOW;
               else begin cwe = 1'b1; cwd = cnt_rd - 1'b1; end
            end
            state_in = S_RESP;
         end
         // head link read issued; nxt_rd valid now
         S_HEAD_RD: begin
            cur_in = nxt_rd; steps_in = '0;
            la = nxt_rd; ta = nxt_rd[BW-1:0];
            state_in = (sub_ff == 2'd0) ? S_HIT_WALK : S_FREE_WALK;
            sub_in = 2'd1;
         end
         // sub 1: data for cur_ff arriving, sub 0 means issue
         S_HIT_WALK: begin
            if (!is_buf || cur_ff == head_ff || steps_ff >= 7'(BUFFERS)) begin
               la = head_ff; sub_in = 2'd2; state_in = S_HEAD_RD;
            end else if (sub_ff == 2'd0) begin
               la = cur_ff; sub_in = 2'd1;
            end else if (tdev_rd == rq_ff.device && tblk_rd == rq_ff.block_number)
            begin
               rs_in.tag_hit = 1'b1; rs_in.granted_buffer = 5'(cur_ff);
               state_in = S_HIT_WR;
            end else begin
               cur_in = nxt_rd; steps_in = steps_ff + 1'b1;
               la = nxt_rd; ta = nxt_rd[BW-1:0];
            end
            if (sub_ff == 2'd0) ta = cur_ff[BW-1:0];
         end
         S_HIT_WR: begin
            if (cnt_rd == COUNT_MAX) rs_in.status = ST_SATURATED;
            else begin cwe = 1'b1; cwd = cnt_rd + 1'b1; end
            rs_in.needs_disk_read = ~valid_ff[cur_ff[BW-1:0]];
            valid_in[cur_ff[BW-1:0]] = 1'b1;
            state_in = S_RESP;
         end
         S_FREE_WALK: begin
            if (!is_buf || cur_ff == head_ff || steps_ff >= 7'(BUFFERS)) begin
               // next bucket to steal from
               steal_in = 1'b1;
               bk_in = steal_ff ? bk_ff + 1'b1 : '0;
               if (steal_ff ? (bk_ff + 1'b1 == home_ff) : (home_ff == '0))
                  bk_in = bk_in + 1'b1;
               if (32'(bk_in) >= 32'(BUCKETS)) begin
                  rs_in = '{granted_buffer: 5'd0, tag_hit: 1'b0,
                            needs_disk_read: 1'b0, status: ST_NO_FREE};
                  state_in = S_RESP;
               end else begin
                  head_in = NW'(BUFFERS) + NW'(bk_in);
                  la = NW'(BUFFERS) + NW'(bk_in);
                  sub_in = 2'd2; state_in = S_HEAD_RD;
               end
            end else if (cnt_rd == '0) begin
               p_in = prv_rd; q_in = nxt_rd;
               state_in = steal_ff ? S_UNLINK : S_RETAG;
               hnode = NW'(BUFFERS) + NW'(home_ff);
               la = hnode;
            end else begin
               cur_in = nxt_rd; steps_in = steps_ff + 1'b1;
               la = nxt_rd; ta = nxt_rd[BW-1:0];
            end
         end
         // unlink: next[p]=q, prev[q]=p (two writes, made in turn)
         S_UNLINK: begin
            if (sub_ff != 2'd3) begin
               lwa = p_ff; lnwd = q_ff; lnwe = p_ff < NW'(NODES);
               hnode = NW'(BUFFERS) + NW'(home_ff); la = hnode;
               sub_in = 2'd3;
            end else begin
               lwa = q_ff; lpwd = p_ff; lpwe = q_ff < NW'(NODES);
               hnode = NW'(BUFFERS) + NW'(home_ff); la = hnode;
               sub_in = 2'd0; state_in = S_PUSH;
            end
         end
         // push front: nxt_rd holds first of home
         S_PUSH: begin
            hnode = NW'(BUFFERS) + NW'(home_ff);
            case (sub_ff)
               2'd0: begin
                  lwa = cur_ff; lnwd = nxt_rd; lpwd = hnode; lnwe = 1'b1; lpwe = 1'b1;
                  q_in = nxt_rd; sub_in = 2'd1;
               end
               2'd1: begin
                  lwa = q_ff; lpwd = cur_ff; lpwe = q_ff < NW'(NODES); sub_in = 2'd2;
               end
               default: begin
                  lwa = hnode; lnwd = cur_ff; lnwe = 1'b1; state_in = S_RETAG;
               end
            endcase
         end
         S_RETAG: begin
            twe = 1'b1; cwe = 1'b1; cwd = 8'd1;
            rs_in.granted_buffer = 5'(cur_ff);
            rs_in.needs_disk_read = 1'b1;
            valid_in[cur_ff[BW-1:0]] = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp.valid = 1'b1;
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && rsp.ready) |=> state_ff == S_IDLE)
      else $error("response not retired");
   a_nofree_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rs_ff.status == ST_NO_FREE) |-> rs_ff.granted_buffer == 5'd0)
      else $error("no-free grant nonzero");
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rs_ff.tag_hit) |-> rq_ff.action == ACT_GET)
      else $error("hit on non-get");
`endif
endmodule

### dv/hbbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbbc_checker
// Watches request and response words, predicts each response from a local
// copy of the tag table and bucket lists, and compares field by field.
// ----------------------------------------------------------------------------
module hbbc_checker
   import hbbc_pkg::*;
#(
   parameter int BUFFERS = BUFFERS_DEF,
   parameter int BUCKETS = BUCKETS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   localparam int NODES = BUFFERS + BUCKETS;

   logic [7:0]  tag_dev   [BUFFERS];
   logic [31:0] tag_blk   [BUFFERS];
   logic        valid_bit [BUFFERS];
   logic [7:0]  ref_cnt   [BUFFERS];
   int          nxt_link  [NODES];
   int          prv_link  [NODES];

   rsp_type expected_rsp_q[$];

   function automatic int next_node(int n);
      return (n < NODES) ? nxt_link[n] : BUFFERS;
   endfunction

   function automatic void put_head(int bkt, int n);
      int h;
      int first;
      h = BUFFERS + bkt;
      first = nxt_link[h];
      nxt_link[n] = first;
      prv_link[n] = h;
      if (first < NODES) prv_link[first] = n;
      nxt_link[h] = n;
   endfunction

   function automatic int first_unreferenced(int bkt);
      int h;
      int n;
      int steps;
      h = BUFFERS + bkt;
      n = next_node(h);
      steps = 0;
      while (n != h && n < BUFFERS && steps < BUFFERS) begin
         if (ref_cnt[n] == 0) return n;
         n = next_node(n);
         steps++;
      end
      return -1;
   endfunction

   task automatic clear_table();
      for (int i = 0; i < BUFFERS; i++) begin
         tag_dev[i] = '0;
         tag_blk[i] = '0;
         valid_bit[i] = 1'b0;
         ref_cnt[i] = '0;
      end
      for (int i = 0; i < BUCKETS; i++) begin
         nxt_link[BUFFERS + i] = BUFFERS + i;
         prv_link[BUFFERS + i] = BUFFERS + i;
      end
      for (int i = 0; i < BUFFERS; i++) put_head(0, i);
   endtask

   function automatic rsp_type predict_response(req_type r);
      rsp_type o;
      int home;
      int h;
      int n;
      int steps;
      int found;
      int p;
      int q;
      o.granted_buffer = r.buffer_index;
      o.tag_hit = 1'b0;
      o.needs_disk_read = 1'b0;
      o.status = ST_OK;
      if (action_type'(r.action) == ACT_GET) begin
         home = int'(r.block_number % BUCKETS);
         h = BUFFERS + home;
         n = next_node(h);
         steps = 0;
         found = -1;
         while (n != h && n < BUFFERS && steps < BUFFERS) begin
            if (tag_dev[n] == r.device && tag_blk[n] == r.block_number) begin
               found = n;
               break;
            end
            n = next_node(n);
            steps++;
         end
         if (found >= 0) begin
            o.tag_hit = 1'b1;
            if (ref_cnt[found] == COUNT_MAX) o.status = ST_SATURATED;
            else ref_cnt[found]++;
         end else begin
            found = first_unreferenced(home);
            if (found < 0) begin
               for (int i = 0; i < BUCKETS && found < 0; i++)
                  if (i != home) found = first_unreferenced(i);
               if (found >= 0) begin
                  p = prv_link[found];
                  q = nxt_link[found];
                  if (p < NODES) nxt_link[p] = q;
                  if (q < NODES) prv_link[q] = p;
                  put_head(home, found);
               end
            end
            if (found >= 0) begin
               tag_dev[found] = r.device;
               tag_blk[found] = r.block_number;
               valid_bit[found] = 1'b0;
               ref_cnt[found] = 8'd1;
            end
         end
         if (found < 0) begin
            o.granted_buffer = '0;
            o.status = ST_NO_FREE;
         end else begin
            o.granted_buffer = found[4:0];
            o.needs_disk_read = !valid_bit[found];
            valid_bit[found] = 1'b1;
         end
      end else if (int'(r.buffer_index) < BUFFERS) begin
         if (action_type'(r.action) == ACT_PIN) begin
            if (ref_cnt[r.buffer_index] == COUNT_MAX) o.status = ST_SATURATED;
            else ref_cnt[r.buffer_index]++;
         end else begin
            if (ref_cnt[r.buffer_index] == 0) o.status = ST_UNDERFLOW;
            else ref_cnt[r.buffer_index]--;
         end
      end
      return o;
   endfunction

   assign pending_count = expected_rsp_q.size();

   always @(posedge clock) begin
      rsp_type exp_rsp;
      int errs;
      errs = 0;
      if (reset) begin
         clear_table();
         expected_rsp_q.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready) expected_rsp_q.push_back(predict_response(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response word with nothing expected");
               errs++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_data.granted_buffer !== exp_rsp.granted_buffer) begin
                  $error("granted_buffer: expected %0d, got %0d",
                         exp_rsp.granted_buffer, rsp_data.granted_buffer);
                  errs++;
               end
               if (rsp_data.tag_hit !== exp_rsp.tag_hit) begin
                  $error("tag_hit: expected %0d, got %0d", exp_rsp.tag_hit, rsp_data.tag_hit);
                  errs++;
               end
               if (rsp_data.needs_disk_read !== exp_rsp.needs_disk_read) begin
                  $error("needs_disk_read: expected %0d, got %0d",
                         exp_rsp.needs_disk_read, rsp_data.needs_disk_read);
                  errs++;
               end
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, rsp_data.status);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end

endmodule

### dv/hashed_block_buffer_cache_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_unit_tb
// Directed and random gets, releases, pins and unpins with random gaps on
// both channels; a checker module predicts and compares every response.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache_unit_tb;
   import hbbc_pkg::*;

   localparam int RANDOM_WORDS = 863;
   localparam int STALL_LIMIT  = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   idle_cycles;
   logic [31:0] recent_blk[8];
   logic [7:0]  recent_dev[8];

   hbbc_if #(.word_type(req_type)) req ();
   hbbc_if #(.word_type(rsp_type)) rsp ();

   hashed_block_buffer_cache_unit u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   hbbc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: cycles with no word accepted on either side
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // response side stalls; ready stays up when the next gap is zero
   initial begin
      int gap;
      rsp.ready = 1'b0;
      @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10));
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
      end
   end

   // valid stays up after acceptance when the next word follows at once
   task automatic send_word(action_type act, logic [7:0] dev, logic [31:0] blk,
                            logic [4:0] idx, int gap);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.data <= '{action: act, device: dev, block_number: blk, buffer_index: idx};
      req.valid <= 1'b1;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   function automatic int draw_gap(int burst);
      return burst ? 0 : int'($urandom_range(0, 10));
   endfunction

   initial begin
      int r;
      int burst;
      int slot;
      logic [31:0] blk;
      req.valid = 1'b0;
      req.data = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 8; i++) begin
         recent_blk[i] = $urandom;
         recent_dev[i] = 8'($urandom);
      end

      // directed: tag zero hit, extremes, each action, underflow
      send_word(ACT_GET, 8'd0, 32'd0, 5'd0, 0);
      send_word(ACT_GET, 8'd0, 32'd0, 5'd0, 0);
      send_word(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31, 1);
      send_word(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 0);
      send_word(ACT_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd5, 2);
      send_word(ACT_UNPIN, 8'h00, 32'd0, 5'd5, 0);
      send_word(ACT_PIN, 8'hAA, 32'h5555_5555, 5'd5, 0);
      send_word(ACT_UNPIN, 8'h55, 32'hAAAA_AAAA, 5'd5, 0);
      send_word(ACT_PIN, 8'h00, 32'd0, 5'd31, 3);
      send_word(ACT_RELEASE, 8'h00, 32'd0, 5'd31, 0);
      // saturate buffer 7, then pin it once more and unpin it back to zero
      for (int i = 0; i < 255; i++) send_word(ACT_PIN, 8'd0, 32'd0, 5'd7, 0);
      send_word(ACT_PIN, 8'd0, 32'd0, 5'd7, 0);
      for (int i = 0; i < 255; i++) send_word(ACT_UNPIN, 8'd0, 32'd0, 5'd7, 0);
      // pin everything: gets must report no free buffer
      for (int i = 0; i < 32; i++) send_word(ACT_PIN, 8'd0, 32'd0, i[4:0], 0);
      send_word(ACT_GET, 8'h12, 32'd1234, 5'd0, 0);
      send_word(ACT_GET, 8'hFE, 32'd12, 5'd0, 0);
      for (int i = 0; i < 32; i++) send_word(ACT_UNPIN, 8'd0, 32'd0, i[4:0], 0);

      // hold off until every response is back
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 50 == 0) burst = int'($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         slot = $urandom_range(0, 7);
         if (r < 45) begin
            // gets on a small working set so hits, reuse and stealing occur
            if ($urandom_range(0, 2) == 0) begin
               recent_blk[slot] = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 40);
               recent_dev[slot] = 8'($urandom);
            end
            blk = recent_blk[slot];
            send_word(ACT_GET, recent_dev[slot], blk, 5'($urandom), draw_gap(burst));
         end else if (r < 75) begin
            send_word(ACT_RELEASE, 8'($urandom), $urandom, 5'($urandom), draw_gap(burst));
         end else if (r < 88) begin
            send_word(ACT_UNPIN, 8'($urandom), $urandom, 5'($urandom), draw_gap(burst));
         end else begin
            send_word(ACT_PIN, 8'($urandom), $urandom, 5'($urandom), draw_gap(burst));
         end
      end

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
